// ===== src/ssfp_pkg.sv =====
`timescale 1ns / 1ps
// Package for the serial frame parser: codes, frame position constants
// and the result record shared by the parser core and the output buffer.
// No dependencies.
package ssfp_pkg;

    // Parser phase.
    typedef enum logic [1:0] {
        PH_HUNT   = 2'd0,
        PH_HEADER = 2'd1,
        PH_DATA   = 2'd2
    } phase_t;

    // Event code carried by every result.
    typedef enum logic [1:0] {
        EV_BYTE  = 2'd0,
        EV_DONE  = 2'd1,
        EV_NO_LF = 2'd2,
        EV_SHORT = 2'd3
    } event_t;

    localparam int unsigned POS_W = 17;

    localparam logic [7:0] START_CHAR = 8'h40;
    localparam logic [7:0] LINE_FEED  = 8'h0A;

    // Header byte positions; the start character is position 1.
    localparam logic [POS_W-1:0] POS_START   = 17'd1;
    localparam logic [POS_W-1:0] POS_LEN_LO  = 17'd6;
    localparam logic [POS_W-1:0] POS_LEN_HI  = 17'd7;
    localparam logic [POS_W-1:0] POS_TX_NODE = 17'd8;
    localparam logic [POS_W-1:0] POS_RX_NODE = 17'd9;
    localparam logic [POS_W-1:0] POS_COUNT   = 17'd10;
    localparam logic [POS_W-1:0] POS_TYPE    = 17'd11;

    // The line feed sits at position length + 6.
    localparam logic [POS_W-1:0] LF_OFFSET  = 17'd6;
    localparam logic [15:0]      MIN_LENGTH = 16'd6;

    // One result transaction.
    typedef struct packed {
        event_t           event_res;
        logic [7:0]       byte_value;
        logic [POS_W-1:0] position;
        logic [15:0]      bin_length;
        logic [7:0]       tx_node;
        logic [7:0]       rx_node;
        logic [7:0]       seq_count;
        logic [7:0]       msg_type;
        logic             frame_end;
    } res_t;

endpackage

// ===== src/ssfp_parse_core.sv =====
`timescale 1ns / 1ps
// Frame parser core: frame state registers and the per-byte update logic.
// Depends on ssfp_pkg.
module ssfp_parse_core
    import ssfp_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       take,
    input  logic [7:0] rx_byte,
    output logic       res_valid,
    output res_t       res
);

    phase_t           phase_reg, phase_next;
    logic [POS_W-1:0] frame_pos_reg, frame_pos_next;
    logic [15:0]      length_reg, length_next;
    logic [7:0]       source_node_reg, source_node_next;
    logic [7:0]       dest_node_reg, dest_node_next;
    logic [7:0]       count_reg, count_next;
    logic [7:0]       type_reg, type_next;
    logic [POS_W-1:0] pos_inc;
    logic [15:0]      full_length;
    logic             has_result;
    logic             frame_done;
    event_t           ev;

    // Next frame state and the result for the byte at the input.
    always_comb
    begin
        phase_next       = phase_reg;
        frame_pos_next   = frame_pos_reg;
        length_next      = length_reg;
        source_node_next = source_node_reg;
        dest_node_next   = dest_node_reg;
        count_next       = count_reg;
        type_next        = type_reg;
        has_result       = 1'b0;
        frame_done       = 1'b0;
        ev               = EV_BYTE;
        pos_inc          = frame_pos_reg + POS_START;
        full_length      = {rx_byte, length_reg[7:0]};

        case (phase_reg)
            PH_HEADER:
            begin
                has_result     = 1'b1;
                frame_pos_next = pos_inc;
                case (pos_inc)
                    POS_LEN_LO:  length_next = {8'd0, rx_byte};
                    POS_LEN_HI:
                    begin
                        length_next = full_length;
                        if (full_length < MIN_LENGTH)
                        begin
                            ev         = EV_SHORT;
                            frame_done = 1'b1;
                        end
                    end
                    POS_TX_NODE: source_node_next = rx_byte;
                    POS_RX_NODE: dest_node_next   = rx_byte;
                    POS_COUNT:   count_next       = rx_byte;
                    POS_TYPE:
                    begin
                        type_next  = rx_byte;
                        phase_next = PH_DATA;
                    end
                    default: ;
                endcase
            end
            PH_DATA:
            begin
                has_result     = 1'b1;
                frame_pos_next = pos_inc;
                if (pos_inc == ({1'b0, length_reg} + LF_OFFSET))
                begin
                    ev         = (rx_byte == LINE_FEED) ? EV_DONE : EV_NO_LF;
                    frame_done = 1'b1;
                end
            end
            default:
            begin
                // Hunting: only the start character opens a frame.
                if (rx_byte == START_CHAR)
                begin
                    has_result       = 1'b1;
                    phase_next       = PH_HEADER;
                    frame_pos_next   = POS_START;
                    length_next      = 16'd0;
                    source_node_next = 8'd0;
                    dest_node_next   = 8'd0;
                    count_next       = 8'd0;
                    type_next        = 8'd0;
                end
                else
                begin
                    phase_next = PH_HUNT;
                end
            end
        endcase

        // The result shows the captured fields before any end-of-frame clear.
        res.event_res  = ev;
        res.byte_value = rx_byte;
        res.position   = frame_pos_next;
        res.bin_length = length_next;
        res.tx_node    = source_node_next;
        res.rx_node    = dest_node_next;
        res.seq_count  = count_next;
        res.msg_type   = type_next;
        res.frame_end  = frame_done;

        if (frame_done)
        begin
            phase_next       = PH_HUNT;
            frame_pos_next   = '0;
            length_next      = 16'd0;
            source_node_next = 8'd0;
            dest_node_next   = 8'd0;
            count_next       = 8'd0;
            type_next        = 8'd0;
        end
    end

    assign res_valid = take && has_result;

    // Frame state registers, updated once per accepted byte.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg       <= PH_HUNT;
            frame_pos_reg   <= '0;
            length_reg      <= 16'd0;
            source_node_reg <= 8'd0;
            dest_node_reg   <= 8'd0;
            count_reg       <= 8'd0;
            type_reg        <= 8'd0;
        end
        else if (take)
        begin
            phase_reg       <= phase_next;
            frame_pos_reg   <= frame_pos_next;
            length_reg      <= length_next;
            source_node_reg <= source_node_next;
            dest_node_reg   <= dest_node_next;
            count_reg       <= count_next;
            type_reg        <= type_next;
        end
    end

    // A frame end always sends the parser back to hunting.
    a_end_to_hunt: assert property (@(posedge clk) disable iff (!rst_n)
        (res_valid && res.frame_end) |=> (phase_reg == PH_HUNT))
        else $error("parser did not return to hunting after frame end");

    // Only error and completion results close a frame.
    a_end_matches_event: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid |-> (res.frame_end == (res.event_res != EV_BYTE)))
        else $error("frame_end disagrees with event code");

    // Hunting only reports the start character.
    a_hunt_start_only: assert property (@(posedge clk) disable iff (!rst_n)
        (res_valid && (phase_reg == PH_HUNT)) |->
            ((rx_byte == START_CHAR) && (res.position == POS_START)))
        else $error("result while hunting without a start character");

endmodule

// ===== src/ssfp_out_buf.sv =====
`timescale 1ns / 1ps
// Result register with a skid stage, so the input can take one more result
// while a finished result waits. Depends on ssfp_pkg.
module ssfp_out_buf
    import ssfp_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    input  logic push,
    input  res_t push_data,
    output logic full,
    output logic out_valid,
    input  logic out_stall,
    output res_t out_data
);

    logic out_valid_reg, out_valid_next;
    logic skid_valid_reg, skid_valid_next;
    res_t out_data_reg, out_data_next;
    res_t skid_data_reg, skid_data_next;
    logic out_fire;

    assign out_fire = out_valid_reg && !out_stall;

    // Buffer control: drain the skid stage first, else load or park the result.
    always_comb
    begin
        out_valid_next  = out_valid_reg;
        skid_valid_next = skid_valid_reg;
        out_data_next   = out_data_reg;
        skid_data_next  = skid_data_reg;
        if (skid_valid_reg)
        begin
            if (out_fire)
            begin
                out_data_next   = skid_data_reg;
                skid_valid_next = 1'b0;
            end
        end
        else if (!out_valid_reg || out_fire)
        begin
            out_valid_next = push;
            out_data_next  = push_data;
        end
        else if (push)
        begin
            skid_valid_next = 1'b1;
            skid_data_next  = push_data;
        end
    end

    // Valid flags.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg  <= out_valid_next;
            skid_valid_reg <= skid_valid_next;
        end
    end

    // Payload registers.
    always_ff @(posedge clk)
    begin
        out_data_reg  <= out_data_next;
        skid_data_reg <= skid_data_next;
    end

    assign full      = skid_valid_reg;
    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

    // The skid stage only fills behind an occupied result register.
    a_skid_behind_out: assert property (@(posedge clk) disable iff (!rst_n)
        skid_valid_reg |-> out_valid_reg)
        else $error("skid stage holds data while the result register is empty");

endmodule

// ===== src/sonar_serial_frame_parser.sv =====
`timescale 1ns / 1ps
// Serial frame parser top level: one received byte per input transaction.
// The result of an accepted byte is registered. Throughput: one byte per cycle
// while in_stall is low; the two-entry result buffer keeps input open while one
// result is stalled. Bytes outside a frame produce no result.
// Reset (rst_n, asynchronous, active low) returns the parser to hunting.
module sonar_serial_frame_parser
    import ssfp_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_stall,
    input  logic [7:0]        rx_byte,
    output logic              out_valid,
    input  logic              out_stall,
    output logic [1:0]        event_res,
    output logic [7:0]        byte_value,
    output logic [POS_W-1:0]  position,
    output logic [15:0]       bin_length,
    output logic [7:0]        tx_node,
    output logic [7:0]        rx_node,
    output logic [7:0]        seq_count,
    output logic [7:0]        msg_type,
    output logic              frame_end
);

    logic take;
    logic res_valid;
    logic buf_full;
    res_t res;
    res_t out_data;

    assign in_stall = buf_full;
    assign take     = in_valid && !buf_full;

    // Per-byte parsing and frame state.
    ssfp_parse_core u_core (
        .clk       (clk),
        .rst_n     (rst_n),
        .take      (take),
        .rx_byte   (rx_byte),
        .res_valid (res_valid),
        .res       (res)
    );

    // Result register and skid stage.
    ssfp_out_buf u_out_buf (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (res_valid),
        .push_data (res),
        .full      (buf_full),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_data  (out_data)
    );

    assign event_res  = out_data.event_res;
    assign byte_value = out_data.byte_value;
    assign position   = out_data.position;
    assign bin_length = out_data.bin_length;
    assign tx_node    = out_data.tx_node;
    assign rx_node    = out_data.rx_node;
    assign seq_count  = out_data.seq_count;
    assign msg_type   = out_data.msg_type;
    assign frame_end  = out_data.frame_end;

endmodule
